[rtl/dlts_pkg.sv]
// ----------------------------------------------------------------------------
// dlts_pkg
// Shared types, token kind codes and keyword tables for the token scanner.
// ----------------------------------------------------------------------------
package dlts_pkg;

  localparam int LINE_BITS   = 20;
  localparam int LENGTH_BITS = 16;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

  localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;
  localparam logic [LENGTH_BITS-1:0] LEN_MAX  = '1;

  // token kinds
  localparam logic [4:0] K_COMMA     = 5'd0;
  localparam logic [4:0] K_PERIOD    = 5'd1;
  localparam logic [4:0] K_QMARK     = 5'd2;
  localparam logic [4:0] K_LPAREN    = 5'd3;
  localparam logic [4:0] K_RPAREN    = 5'd4;
  localparam logic [4:0] K_COLON     = 5'd5;
  localparam logic [4:0] K_COLONDASH = 5'd6;
  localparam logic [4:0] K_MUL       = 5'd7;
  localparam logic [4:0] K_ADD       = 5'd8;
  localparam logic [4:0] K_KW0       = 5'd9;
  localparam logic [4:0] K_ID        = 5'd13;
  localparam logic [4:0] K_STRING    = 5'd14;
  localparam logic [4:0] K_COMMENT   = 5'd15;
  localparam logic [4:0] K_UNDEF     = 5'd16;
  localparam logic [4:0] K_EOF       = 5'd17;

  // input operations
  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_END  = 1'b1;

  // character codes
  localparam logic [7:0] CH_TAB    = 8'd9;
  localparam logic [7:0] CH_LF     = 8'd10;
  localparam logic [7:0] CH_CR     = 8'd13;
  localparam logic [7:0] CH_SPACE  = 8'd32;
  localparam logic [7:0] CH_QUOTE  = 8'd39;
  localparam logic [7:0] CH_LPAREN = 8'd40;
  localparam logic [7:0] CH_RPAREN = 8'd41;
  localparam logic [7:0] CH_STAR   = 8'd42;
  localparam logic [7:0] CH_PLUS   = 8'd43;
  localparam logic [7:0] CH_COMMA  = 8'd44;
  localparam logic [7:0] CH_DASH   = 8'd45;
  localparam logic [7:0] CH_PERIOD = 8'd46;
  localparam logic [7:0] CH_HASH   = 8'd35;
  localparam logic [7:0] CH_COLON  = 8'd58;
  localparam logic [7:0] CH_QMARK  = 8'd63;
  localparam logic [7:0] CH_BAR    = 8'd124;
  localparam logic [7:0] CH_DIG_LO = 8'd48;
  localparam logic [7:0] CH_DIG_HI = 8'd57;
  localparam logic [7:0] CH_UC_LO  = 8'd65;
  localparam logic [7:0] CH_UC_HI  = 8'd90;
  localparam logic [7:0] CH_LC_LO  = 8'd97;
  localparam logic [7:0] CH_LC_HI  = 8'd122;

  typedef enum logic [3:0] {
    M_IDLE, M_IDENT, M_COLON, M_HASH, M_LINECOM, M_STRING, M_SQUOTE, M_BLOCK, M_BBAR
  } dlts_mode_t;

  typedef struct packed {
    logic       op;
    logic [7:0] char_code;
  } dlts_in_t;

  typedef struct packed {
    logic [4:0]             token_kind;
    logic [LINE_BITS-1:0]   token_line;
    logic [LENGTH_BITS-1:0] lexeme_length;
    logic                   last_token;
  } dlts_out_t;

  // up to two tokens produced by one transaction, in order
  typedef struct packed {
    logic [1:0] num;
    dlts_out_t  first;
    dlts_out_t  second;
  } dlts_push_t;

  // keyword text, left aligned, zero padded to eight bytes
  function automatic logic [7:0] kw_char(logic [1:0] k, logic [2:0] pos);
    logic [63:0] txt;
    unique case (k)
      2'd0:    txt = {"Schemes", 8'h00};
      2'd1:    txt = {"Facts", 24'h0};
      2'd2:    txt = {"Rules", 24'h0};
      default: txt = {"Queries", 8'h00};
    endcase
    return txt[(7 - int'(pos)) * 8 +: 8];
  endfunction

  function automatic logic [3:0] kw_len(logic [1:0] k);
    unique case (k)
      2'd0:    return 4'd7;
      2'd1:    return 4'd5;
      2'd2:    return 4'd5;
      default: return 4'd7;
    endcase
  endfunction

endpackage

[rtl/dlts_scanner.sv]
// ----------------------------------------------------------------------------
// dlts_scanner
// Lexer state and the one-character transition; emits up to two tokens.
// ----------------------------------------------------------------------------
module dlts_scanner
  import dlts_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step_en,
  input  dlts_in_t   in_item,
  output dlts_push_t push
);

  dlts_mode_t             mode_r, mode_nxt;
  logic [LINE_BITS-1:0]   line_r, line_nxt;
  logic [LINE_BITS-1:0]   start_r, start_nxt;
  logic [LENGTH_BITS-1:0] len_r, len_nxt;
  logic [2:0]             kwp_r, kwp_nxt;

  logic [7:0]             c;
  logic                   is_letter, is_alnum;
  logic [LINE_BITS-1:0]   line_inc;
  logic [LENGTH_BITS-1:0] len_inc;
  logic [1:0]             kw_idx;
  logic [4:0]             ident_kind;
  logic                   a_vld, b_vld, rescan;
  dlts_out_t              tok_a, tok_b;

  assign c         = in_item.char_code;
  assign is_letter = (c >= CH_UC_LO && c <= CH_UC_HI) || (c >= CH_LC_LO && c <= CH_LC_HI);
  assign is_alnum  = is_letter || (c >= CH_DIG_LO && c <= CH_DIG_HI);
  assign line_inc  = (line_r == LINE_MAX) ? line_r : line_r + 1'b1;
  assign len_inc   = (len_r == LEN_MAX) ? len_r : len_r + 1'b1;
  assign kw_idx    = 2'(kwp_r - 3'd1);

  always_comb begin
    ident_kind = K_ID;
    if (kwp_r >= 3'd1 && kwp_r <= 3'd4 &&
        len_r == LENGTH_BITS'(kw_len(kw_idx))) begin
      ident_kind = K_KW0 + 5'(kw_idx);
    end
  end

  always_comb begin
    mode_nxt  = mode_r;
    line_nxt  = line_r;
    start_nxt = start_r;
    len_nxt   = len_r;
    kwp_nxt   = kwp_r;
    a_vld     = 1'b0;
    b_vld     = 1'b0;
    rescan    = 1'b0;
    tok_a     = '0;
    tok_b     = '0;

    if (step_en) begin
      if (in_item.op == OP_END) begin
        tok_a.token_line    = start_r;
        tok_a.lexeme_length = len_r;
        unique case (mode_r)
          M_IDENT: begin
            a_vld = 1'b1;
            tok_a.token_kind = ident_kind;
          end
          M_COLON: begin
            a_vld = 1'b1;
            tok_a.token_kind    = K_COLON;
            tok_a.lexeme_length = LENGTH_BITS'(1);
          end
          M_HASH, M_LINECOM: begin
            a_vld = 1'b1;
            tok_a.token_kind = K_COMMENT;
          end
          M_SQUOTE: begin
            a_vld = 1'b1;
            tok_a.token_kind = K_STRING;
          end
          M_STRING, M_BLOCK, M_BBAR: begin
            a_vld = 1'b1;
            tok_a.token_kind = K_UNDEF;
          end
          default: a_vld = 1'b0;
        endcase
        b_vld = 1'b1;
        tok_b.token_kind    = K_EOF;
        tok_b.token_line    = line_r;
        tok_b.lexeme_length = '0;
        mode_nxt  = M_IDLE;
        line_nxt  = LINE_BITS'(1);
        start_nxt = '0;
        len_nxt   = '0;
        kwp_nxt   = '0;
      end else begin
        tok_a.token_line    = start_r;
        tok_a.lexeme_length = len_r;
        unique case (mode_r)
          M_IDENT: begin
            if (is_alnum) begin
              if (kwp_r >= 3'd1 && kwp_r <= 3'd4) begin
                if (len_r >= LENGTH_BITS'(kw_len(kw_idx)) ||
                    kw_char(kw_idx, len_r[2:0]) != c) begin
                  kwp_nxt = '0;
                end
              end else begin
                kwp_nxt = '0;
              end
              len_nxt = len_inc;
            end else begin
              a_vld = 1'b1;
              tok_a.token_kind = ident_kind;
              kwp_nxt = '0;
              rescan  = 1'b1;
            end
          end
          M_COLON: begin
            a_vld = 1'b1;
            if (c == CH_DASH) begin
              tok_a.token_kind    = K_COLONDASH;
              tok_a.lexeme_length = LENGTH_BITS'(2);
              mode_nxt = M_IDLE;
            end else begin
              tok_a.token_kind    = K_COLON;
              tok_a.lexeme_length = LENGTH_BITS'(1);
              rescan = 1'b1;
            end
          end
          M_HASH: begin
            if (c == CH_BAR) begin
              mode_nxt = M_BLOCK;
              len_nxt  = len_inc;
            end else if (c == CH_LF) begin
              a_vld = 1'b1;
              tok_a.token_kind = K_COMMENT;
              rescan = 1'b1;
            end else begin
              mode_nxt = M_LINECOM;
              len_nxt  = len_inc;
            end
          end
          M_LINECOM: begin
            if (c == CH_LF) begin
              a_vld = 1'b1;
              tok_a.token_kind = K_COMMENT;
              rescan = 1'b1;
            end else begin
              len_nxt = len_inc;
            end
          end
          M_STRING: begin
            len_nxt = len_inc;
            if (c == CH_LF) line_nxt = line_inc;
            if (c == CH_QUOTE) mode_nxt = M_SQUOTE;
          end
          M_SQUOTE: begin
            if (c == CH_QUOTE) begin
              len_nxt  = len_inc;
              mode_nxt = M_STRING;
            end else begin
              a_vld = 1'b1;
              tok_a.token_kind = K_STRING;
              rescan = 1'b1;
            end
          end
          M_BLOCK, M_BBAR: begin
            len_nxt = len_inc;
            if (c == CH_LF) line_nxt = line_inc;
            if (mode_r == M_BBAR && c == CH_HASH) begin
              a_vld = 1'b1;
              tok_a.token_kind    = K_COMMENT;
              tok_a.lexeme_length = len_inc;
              mode_nxt = M_IDLE;
            end else begin
              mode_nxt = (c == CH_BAR) ? M_BBAR : M_BLOCK;
            end
          end
          default: rescan = 1'b1;
        endcase

        // the terminating character is scanned again as a fresh one
        if (rescan) begin
          mode_nxt = M_IDLE;
          tok_b.token_line    = line_r;
          tok_b.lexeme_length = LENGTH_BITS'(1);
          tok_b.token_kind    = K_UNDEF;
          priority if (c == CH_LF) begin
            line_nxt = line_inc;
          end else if ((c >= CH_TAB && c <= CH_CR) || c == CH_SPACE) begin
            b_vld = 1'b0;
          end else if (c == CH_COMMA) begin
            b_vld = 1'b1;
            tok_b.token_kind = K_COMMA;
          end else if (c == CH_PERIOD) begin
            b_vld = 1'b1;
            tok_b.token_kind = K_PERIOD;
          end else if (c == CH_QMARK) begin
            b_vld = 1'b1;
            tok_b.token_kind = K_QMARK;
          end else if (c == CH_LPAREN) begin
            b_vld = 1'b1;
            tok_b.token_kind = K_LPAREN;
          end else if (c == CH_RPAREN) begin
            b_vld = 1'b1;
            tok_b.token_kind = K_RPAREN;
          end else if (c == CH_STAR) begin
            b_vld = 1'b1;
            tok_b.token_kind = K_MUL;
          end else if (c == CH_PLUS) begin
            b_vld = 1'b1;
            tok_b.token_kind = K_ADD;
          end else if (c == CH_COLON || c == CH_HASH || c == CH_QUOTE) begin
            mode_nxt  = (c == CH_COLON) ? M_COLON : (c == CH_HASH) ? M_HASH : M_STRING;
            start_nxt = line_r;
            len_nxt   = LENGTH_BITS'(1);
          end else if (is_letter) begin
            mode_nxt  = M_IDENT;
            start_nxt = line_r;
            len_nxt   = LENGTH_BITS'(1);
            kwp_nxt   = '0;
            for (int k = 0; k < 4; k++) begin
              if (kw_char(2'(k), 3'd0) == c) kwp_nxt = 3'(k + 1);
            end
          end else begin
            b_vld = 1'b1;
          end
        end
      end
    end
  end

  // pack the tokens in order, last one flagged
  always_comb begin
    push = '0;
    if (a_vld && b_vld) begin
      push.num    = 2'd2;
      push.first  = tok_a;
      push.second = tok_b;
      push.second.last_token = 1'b1;
    end else if (a_vld) begin
      push.num   = 2'd1;
      push.first = tok_a;
      push.first.last_token = 1'b1;
    end else if (b_vld) begin
      push.num   = 2'd1;
      push.first = tok_b;
      push.first.last_token = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_IDLE;
      line_r  <= LINE_BITS'(1);
      start_r <= '0;
      len_r   <= '0;
      kwp_r   <= '0;
    end else begin
      mode_r  <= mode_nxt;
      line_r  <= line_nxt;
      start_r <= start_nxt;
      len_r   <= len_nxt;
      kwp_r   <= kwp_nxt;
    end
  end

endmodule

[rtl/dlts_token_fifo.sv]
// ----------------------------------------------------------------------------
// dlts_token_fifo
// Small result queue: up to two tokens in per cycle, one out unless stalled.
// ----------------------------------------------------------------------------
module dlts_token_fifo
  import dlts_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  dlts_push_t push,
  output logic       room,
  output logic       out_valid,
  input  logic       out_stall,
  output dlts_out_t  out_data
);

  dlts_out_t              mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]     wptr_r, wptr_nxt;
  logic [FIFO_AW-1:0]     rptr_r, rptr_nxt;
  logic [FIFO_AW:0]       count_r, count_nxt;
  logic                   pop;

  // room for a worst-case pair regardless of this cycle's pop
  assign room      = count_r <= (FIFO_AW + 1)'(FIFO_DEPTH - 2);
  assign out_valid = count_r != '0;
  assign out_data  = mem[rptr_r];
  assign pop       = out_valid && !out_stall;

  always_comb begin
    wptr_nxt  = wptr_r + FIFO_AW'(push.num);
    rptr_nxt  = pop ? rptr_r + 1'b1 : rptr_r;
    count_nxt = count_r + (FIFO_AW + 1)'(push.num) - (FIFO_AW + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.num != 2'd0) mem[wptr_r] <= push.first;
    if (push.num == 2'd2) mem[wptr_r + 1'b1] <= push.second;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

[rtl/datalog_token_scanner_unit.sv]
// ----------------------------------------------------------------------------
// datalog_token_scanner_unit
// Datalog lexer: one source byte per transaction in, tokens out.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  in_     | input     | in_valid / in_stall   | dlts_in_t  (op, char_code)
//  out_    | output    | out_valid / out_stall | dlts_out_t (kind, line, length, last)
//
// one input transaction per cycle while in_stall is low; it updates the lexer
// state and queues its zero to two tokens, which reach out_ after any older ones.
// output runs one token per cycle while out_stall is low, through a four-entry
// queue; in_stall is high while fewer than two entries are free.
// reset is synchronous: lexer back to idle on line one, queue empty.
// ----------------------------------------------------------------------------
module datalog_token_scanner_unit
  import dlts_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  dlts_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output dlts_out_t out_data
);

  logic       room;
  logic       step_en;
  dlts_push_t push;

  assign in_stall = !room;
  assign step_en  = in_valid && !in_stall;

  dlts_scanner u_scanner (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .in_item (in_data),
    .push    (push)
  );

  dlts_token_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // end of input always yields at least the eof token
  a_end_gives_token: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && in_data.op == OP_END) |=> out_valid)
    else $error("no token after end of input");

  a_eof_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.token_kind == K_EOF) |-> out_data.last_token)
    else $error("eof token not flagged last");

  a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.token_line != '0))
    else $error("token reported on line zero");

  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.token_kind != K_EOF) |-> (out_data.lexeme_length != '0))
    else $error("empty lexeme on a non-eof token");

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Datalog token scanner. A directed table and
// random well-formed source text, with noise and broken tokens mixed in,
// are fed through the byte channel; every token that comes out is compared
// against a scoreboard model of the lexer kept inside the bench.
// ----------------------------------------------------------------------------
module tb_top;
  import dlts_pkg::*;

  localparam int DIR_ROWS    = 27;
  localparam int RAND_ITEMS  = 110;
  localparam int LONG_BYTES  = 24;
  localparam int PRESS_ITEMS = 40;
  localparam int HOLD_CYCLES = 200;
  localparam int DRAIN       = 20;
  localparam int WD_LIMIT    = 2000;

  typedef struct packed {
    logic                   op;
    logic [7:0]             ch;
    logic                   typed;
    logic [4:0]             kind;
    logic [LINE_BITS-1:0]   line;
    logic [LENGTH_BITS-1:0] len;
  } stim_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  dlts_in_t  in_data;
  logic      out_valid;
  logic      out_stall;
  dlts_out_t out_data;

  datalog_token_scanner_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // directed table: typed rows carry the token they must produce
  stim_row_t dir_table [DIR_ROWS] = '{
    '{OP_CHAR, CH_COMMA,  1'b1, K_COMMA,     20'd1, 16'd1},
    '{OP_CHAR, 8'hFF,     1'b1, K_UNDEF,     20'd1, 16'd1},
    '{OP_CHAR, 8'h00,     1'b1, K_UNDEF,     20'd1, 16'd1},
    '{OP_CHAR, CH_COLON,  1'b0, 5'd0,        20'd0, 16'd0},
    '{OP_CHAR, CH_DASH,   1'b1, K_COLONDASH, 20'd1, 16'd2},
    '{OP_CHAR, CH_COLON,  1'b0, 5'd0,        20'd0, 16'd0},
    '{OP_CHAR, CH_LF,     1'b0, 5'd0,        20'd0, 16'd0},
    '{OP_CHAR, "R",       1'b0, 5'd0,        20'd0, 16'd0},
    '{OP_CHAR, "u",       1'b0, 5'd0,        20'd0, 16'd0},
    '{OP_CHAR, "l",       1'b0, 5'd0,        20'd0, 16'd0},
    '{OP_CHAR, "e",       1'b0, 5'd0,        20'd0, 16'd0},
    '{OP_CHAR, "s",       1'b0, 5'd0,        20'd0, 16'd0},
    '{OP_CHAR, CH_LPAREN, 1'b0, 5'd0,        20'd0, 16'd0},
    '{OP_CHAR, CH_HASH,   1'b0, 5'd0,        20'd0, 16'd0},
    '{OP_CHAR, CH_LF,     1'b0, 5'd0,        20'd0, 16'd0},
    '{OP_CHAR, CH_HASH,   1'b0, 5'd0,        20'd0, 16'd0},
    '{OP_CHAR, CH_BAR,    1'b0, 5'd0,        20'd0, 16'd0},
    '{OP_CHAR, CH_HASH,   1'b0, 5'd0,        20'd0, 16'd0},
    '{OP_CHAR, CH_BAR,    1'b0, 5'd0,        20'd0, 16'd0},
    '{OP_CHAR, CH_HASH,   1'b0, 5'd0,        20'd0, 16'd0},
    '{OP_CHAR, CH_QUOTE,  1'b0, 5'd0,        20'd0, 16'd0},
    '{OP_CHAR, "a",       1'b0, 5'd0,        20'd0, 16'd0},
    '{OP_CHAR, CH_QUOTE,  1'b0, 5'd0,        20'd0, 16'd0},
    '{OP_CHAR, CH_QUOTE,  1'b0, 5'd0,        20'd0, 16'd0},
    '{OP_CHAR, "b",       1'b0, 5'd0,        20'd0, 16'd0},
    '{OP_END,  8'h00,     1'b0, 5'd0,        20'd0, 16'd0},
    '{OP_END,  8'hA5,     1'b1, K_EOF,       20'd1, 16'd0}
  };

  string kw_words [4] = '{"Schemes", "Facts", "Rules", "Queries"};

  stim_row_t source_rows[$];
  dlts_out_t pending_tokens[$];
  dlts_out_t step_tokens[$];

  // lexer model state
  dlts_mode_t             lx_mode;
  logic [LINE_BITS-1:0]   lx_line;
  logic [LINE_BITS-1:0]   lx_tok_line;
  logic [LENGTH_BITS-1:0] lx_len;
  logic [2:0]             lx_kw;

  int  n_acc;
  int  n_tok;
  int  errs;
  int  quiet;
  int  long_start;
  int  press_start;
  bit  hold_req;

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= CH_UC_LO && c <= CH_UC_HI) || (c >= CH_LC_LO && c <= CH_LC_HI);
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= CH_DIG_LO && c <= CH_DIG_HI;
  endfunction

  function automatic void lx_clear();
    lx_mode     = M_IDLE;
    lx_line     = LINE_BITS'(1);
    lx_tok_line = '0;
    lx_len      = '0;
    lx_kw       = '0;
  endfunction

  function automatic void lx_emit(logic [4:0] k, logic [LINE_BITS-1:0] ln,
                                  logic [LENGTH_BITS-1:0] len);
    dlts_out_t t;
    t.token_kind    = k;
    t.token_line    = ln;
    t.lexeme_length = len;
    t.last_token    = 1'b0;
    step_tokens.insert(step_tokens.size(), t);
  endfunction

  function automatic void lx_next_line();
    if (lx_line != LINE_MAX) lx_line++;
  endfunction

  function automatic void lx_grow();
    if (lx_len != LEN_MAX) lx_len++;
  endfunction

  function automatic void lx_open(dlts_mode_t m);
    lx_mode     = m;
    lx_tok_line = lx_line;
    lx_len      = LENGTH_BITS'(1);
  endfunction

  function automatic void lx_close_ident();
    logic [4:0] k;
    k = K_ID;
    if (lx_kw != 0 && int'(lx_len) == kw_words[lx_kw - 1].len())
      k = K_KW0 + 5'(lx_kw) - 5'd1;
    lx_emit(k, lx_tok_line, lx_len);
    lx_kw = '0;
  endfunction

  // a byte seen with no token open
  function automatic void lx_fresh_byte(logic [7:0] c);
    lx_mode = M_IDLE;
    if (c == CH_LF) begin
      lx_next_line();
    end else if ((c >= CH_TAB && c <= CH_CR) || c == CH_SPACE) begin
      // skipped
    end else if (c == CH_COMMA) begin
      lx_emit(K_COMMA, lx_line, LENGTH_BITS'(1));
    end else if (c == CH_PERIOD) begin
      lx_emit(K_PERIOD, lx_line, LENGTH_BITS'(1));
    end else if (c == CH_QMARK) begin
      lx_emit(K_QMARK, lx_line, LENGTH_BITS'(1));
    end else if (c == CH_LPAREN) begin
      lx_emit(K_LPAREN, lx_line, LENGTH_BITS'(1));
    end else if (c == CH_RPAREN) begin
      lx_emit(K_RPAREN, lx_line, LENGTH_BITS'(1));
    end else if (c == CH_STAR) begin
      lx_emit(K_MUL, lx_line, LENGTH_BITS'(1));
    end else if (c == CH_PLUS) begin
      lx_emit(K_ADD, lx_line, LENGTH_BITS'(1));
    end else if (c == CH_COLON) begin
      lx_open(M_COLON);
    end else if (c == CH_HASH) begin
      lx_open(M_HASH);
    end else if (c == CH_QUOTE) begin
      lx_open(M_STRING);
    end else if (is_alpha(c)) begin
      lx_open(M_IDENT);
      lx_kw = '0;
      for (int k = 0; k < 4; k++)
        if (kw_words[k].getc(0) == c) lx_kw = 3'(k + 1);
    end else begin
      lx_emit(K_UNDEF, lx_line, LENGTH_BITS'(1));
    end
  endfunction

  function automatic void lx_scan_byte(logic [7:0] c);
    bit rescan;
    int k;
    rescan = 1'b1;
    case (lx_mode)
      M_IDENT: begin
        if (is_alpha(c) || is_digit(c)) begin
          if (lx_kw != 0) begin
            k = lx_kw - 1;
            if (int'(lx_len) >= kw_words[k].len() || kw_words[k].getc(lx_len) != c)
              lx_kw = '0;
          end
          lx_grow();
          rescan = 1'b0;
        end else begin
          lx_close_ident();
        end
      end
      M_COLON: begin
        if (c == CH_DASH) begin
          lx_emit(K_COLONDASH, lx_tok_line, LENGTH_BITS'(2));
          lx_mode = M_IDLE;
          rescan  = 1'b0;
        end else begin
          lx_emit(K_COLON, lx_tok_line, LENGTH_BITS'(1));
        end
      end
      M_HASH: begin
        if (c == CH_BAR) begin
          lx_mode = M_BLOCK;
          lx_grow();
          rescan = 1'b0;
        end else if (c == CH_LF) begin
          lx_emit(K_COMMENT, lx_tok_line, lx_len);
        end else begin
          lx_mode = M_LINECOM;
          lx_grow();
          rescan = 1'b0;
        end
      end
      M_LINECOM: begin
        if (c == CH_LF) begin
          lx_emit(K_COMMENT, lx_tok_line, lx_len);
        end else begin
          lx_grow();
          rescan = 1'b0;
        end
      end
      M_STRING: begin
        lx_grow();
        if (c == CH_LF) lx_next_line();
        if (c == CH_QUOTE) lx_mode = M_SQUOTE;
        rescan = 1'b0;
      end
      M_SQUOTE: begin
        if (c == CH_QUOTE) begin
          lx_grow();
          lx_mode = M_STRING;
          rescan  = 1'b0;
        end else begin
          lx_emit(K_STRING, lx_tok_line, lx_len);
        end
      end
      M_BLOCK, M_BBAR: begin
        lx_grow();
        if (c == CH_LF) lx_next_line();
        if (lx_mode == M_BBAR && c == CH_HASH) begin
          lx_emit(K_COMMENT, lx_tok_line, lx_len);
          lx_mode = M_IDLE;
        end else begin
          lx_mode = (c == CH_BAR) ? M_BBAR : M_BLOCK;
        end
        rescan = 1'b0;
      end
      default: ;
    endcase
    if (rescan) lx_fresh_byte(c);
  endfunction

  function automatic void lx_end_of_input();
    case (lx_mode)
      M_IDENT:           lx_close_ident();
      M_COLON:           lx_emit(K_COLON, lx_tok_line, LENGTH_BITS'(1));
      M_HASH, M_LINECOM: lx_emit(K_COMMENT, lx_tok_line, lx_len);
      M_SQUOTE:          lx_emit(K_STRING, lx_tok_line, lx_len);
      M_STRING, M_BLOCK, M_BBAR: lx_emit(K_UNDEF, lx_tok_line, lx_len);
      default: ;
    endcase
    lx_emit(K_EOF, lx_line, '0);
    lx_clear();
  endfunction

  function automatic void add_byte(logic [7:0] c);
    stim_row_t r;
    r    = '0;
    r.op = OP_CHAR;
    r.ch = c;
    source_rows.insert(source_rows.size(), r);
  endfunction

  function automatic void add_end();
    stim_row_t r;
    r    = '0;
    r.op = OP_END;
    r.ch = 8'($urandom_range(0, 255));
    source_rows.insert(source_rows.size(), r);
  endfunction

  function automatic logic [7:0] rand_letter();
    if ($urandom_range(0, 1) == 0) return CH_UC_LO + 8'($urandom_range(0, 25));
    return CH_LC_LO + 8'($urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] rand_alnum();
    int r;
    r = $urandom_range(0, 61);
    if (r < 10) return CH_DIG_LO + 8'(r);
    if (r < 36) return CH_UC_LO + 8'(r - 10);
    return CH_LC_LO + 8'(r - 36);
  endfunction

  function automatic logic [7:0] rand_punct();
    string p;
    p = ",.?()*+";
    return p.getc($urandom_range(0, 6));
  endfunction

  // mostly well-formed tokens with random content, some noise and broken tokens
  function automatic void gen_source_text(int target);
    int sel, n, k, v;
    logic [7:0] c;
    while (source_rows.size() < target) begin
      sel = $urandom_range(0, 99);
      if (sel < 10) begin
        add_byte(8'($urandom_range(0, 255)));
      end else if (sel < 20) begin
        add_byte(rand_punct());
      end else if (sel < 28) begin
        v = $urandom_range(0, 5);
        add_byte(v == 5 ? CH_SPACE : CH_TAB + 8'(v));
      end else if (sel < 33) begin
        add_byte(CH_COLON);
        if ($urandom_range(0, 2) != 0) add_byte(CH_DASH);
      end else if (sel < 50) begin
        if ($urandom_range(0, 1) == 0) begin
          k = $urandom_range(0, 3);
          v = $urandom_range(0, 2);
          n = (v == 1) ? $urandom_range(1, kw_words[k].len() - 1) : kw_words[k].len();
          for (int i = 0; i < n; i++) add_byte(kw_words[k].getc(i));
          if (v == 2) add_byte(rand_alnum());
        end else begin
          add_byte(rand_letter());
          n = $urandom_range(0, 6);
          for (int i = 0; i < n; i++) add_byte(rand_alnum());
        end
      end else if (sel < 64) begin
        add_byte(CH_QUOTE);
        n = $urandom_range(0, 6);
        for (int i = 0; i < n; i++) begin
          v = $urandom_range(0, 3);
          if (v == 0) begin
            add_byte(CH_QUOTE);
            add_byte(CH_QUOTE);
          end else if (v == 1) begin
            add_byte(CH_LF);
          end else begin
            c = 8'($urandom_range(0, 255));
            add_byte(c == CH_QUOTE ? CH_SPACE : c);
          end
        end
        add_byte(CH_QUOTE);
      end else if (sel < 74) begin
        add_byte(CH_HASH);
        n = $urandom_range(0, 8);
        for (int i = 0; i < n; i++) begin
          c = 8'($urandom_range(0, 255));
          if (c == CH_LF || (i == 0 && c == CH_BAR)) c = rand_letter();
          add_byte(c);
        end
        add_byte(CH_LF);
      end else if (sel < 88) begin
        add_byte(CH_HASH);
        add_byte(CH_BAR);
        n = $urandom_range(0, 8);
        for (int i = 0; i < n; i++) begin
          v = $urandom_range(0, 3);
          if (v == 0)      add_byte(CH_BAR);
          else if (v == 1) add_byte(CH_LF);
          else if (v == 2) add_byte(CH_HASH);
          else             add_byte(8'($urandom_range(0, 255)));
        end
        add_byte(CH_BAR);
        add_byte(CH_HASH);
      end else if (sel < 91) begin
        // opener left dangling; whatever follows lands inside it
        if ($urandom_range(0, 1) == 0) begin
          add_byte(CH_QUOTE);
        end else begin
          add_byte(CH_HASH);
          add_byte(CH_BAR);
        end
        add_byte(rand_alnum());
      end else if (sel < 95) begin
        add_end();
      end else begin
        add_byte(CH_LF);
      end
    end
  endfunction

  // scoreboard: outputs checked first, then the accepted byte is predicted
  always @(posedge clk) begin : p_monitor
    stim_row_t row;
    dlts_out_t want;
    dlts_out_t t;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        n_tok++;
        if (pending_tokens.size() == 0) begin
          $error("token with no expectation waiting: kind %0d line %0d length %0d",
                 out_data.token_kind, out_data.token_line, out_data.lexeme_length);
          errs++;
        end else begin
          want = pending_tokens.pop_front();
          if (out_data.token_kind !== want.token_kind) begin
            $error("token_kind: expected %0d, got %0d", want.token_kind,
                   out_data.token_kind);
            errs++;
          end
          if (out_data.token_line !== want.token_line) begin
            $error("token_line: expected %0d, got %0d", want.token_line,
                   out_data.token_line);
            errs++;
          end
          if (out_data.lexeme_length !== want.lexeme_length) begin
            $error("lexeme_length: expected %0d, got %0d", want.lexeme_length,
                   out_data.lexeme_length);
            errs++;
          end
          if (out_data.last_token !== want.last_token) begin
            $error("last_token: expected %0d, got %0d", want.last_token,
                   out_data.last_token);
            errs++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        row = source_rows[n_acc];
        n_acc++;
        step_tokens.delete();
        if (in_data.op == OP_END) lx_end_of_input();
        else lx_scan_byte(in_data.char_code);
        if (row.typed) begin
          // table row: the token is written out by hand, model state still advances
          step_tokens.delete();
          t.token_kind    = row.kind;
          t.token_line    = row.line;
          t.lexeme_length = row.len;
          t.last_token    = 1'b0;
          step_tokens.insert(step_tokens.size(), t);
        end
        if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last_token = 1'b1;
        foreach (step_tokens[i]) pending_tokens.insert(pending_tokens.size(), step_tokens[i]);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
    else quiet++;
    if (quiet >= WD_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d tokens still expected",
               quiet, pending_tokens.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver: its own stall pattern, plus one long hold-off on request
  initial begin : p_sink
    int mode, run;
    out_stall = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        mode = $urandom_range(0, 3);
        run  = (mode == 3) ? $urandom_range(1, 8) : $urandom_range(1, 30);
        for (int k = 0; k < run && !hold_req; k++) begin
          case (mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            2:       out_stall <= ($urandom_range(0, 1) == 1);
            default: out_stall <= 1'b1;
          endcase
          @(posedge clk);
        end
      end
    end
  end

  initial begin : p_source
    dlts_in_t item;
    int burst_left, gap;
    bit calm;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    n_acc    = 0;
    n_tok    = 0;
    errs     = 0;
    quiet    = 0;
    hold_req = 1'b0;
    lx_clear();

    for (int i = 0; i < DIR_ROWS; i++) source_rows.insert(source_rows.size(), dir_table[i]);
    gen_source_text(DIR_ROWS + RAND_ITEMS);
    add_end();
    // one longer line comment, fed without gaps
    long_start = source_rows.size();
    add_byte(CH_HASH);
    for (int i = 0; i < LONG_BYTES; i++) add_byte("x");
    add_byte(CH_LF);
    add_end();
    press_start = source_rows.size();
    for (int i = 0; i < PRESS_ITEMS; i++) add_byte(rand_punct());
    add_end();

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    burst_left = 0;
    for (int i = 0; i < source_rows.size(); i++) begin
      calm = (i >= long_start);
      if (i == press_start) hold_req = 1'b1;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 20);
        gap = (calm || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left--;
      item.op        = source_rows[i].op;
      item.char_code = source_rows[i].ch;
      in_valid <= 1'b1;
      in_data  <= item;
      @(posedge clk);
      while (in_stall) @(posedge clk);
    end
    in_valid <= 1'b0;

    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (pending_tokens.size() != 0) begin
      $error("%0d expected tokens never arrived", pending_tokens.size());
      errs++;
    end

    $display("fed %0d source transactions (%0d table rows, a %0d-byte comment, %0d under",
             n_acc, DIR_ROWS, LONG_BYTES + 1, PRESS_ITEMS);
    $display("a %0d-cycle output hold) and compared %0d tokens, %0d mismatches",
             HOLD_CYCLES, n_tok, errs);
    if (errs == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
